>>> design/brfc_pkg.sv
// shared types, constants and crc function for the bus request frame checker
package brfc_pkg;

   localparam int TELEMETRY_FRAME_LEN = 8;
   localparam int MENU_FRAME_LEN = 9;
   localparam int WINDOW_DEPTH = 9;
   localparam int BRFC_QUEUE_DEPTH = 2;

   localparam logic [7:0] HDR_START = 8'h3d;
   localparam logic [7:0] HDR_ANSWER = 8'h01;
   localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
   localparam logic [7:0] TELEMETRY_ID_RESET = 8'h3a;
   localparam logic [7:0] MENU_ID_RESET = 8'h3b;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TELEMETRY_ID = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MENU_ID = 1'd1;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_TELEMETRY = 2'd1;
   localparam logic [1:0] STATUS_MENU = 2'd2;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd3;

   localparam int COUNT_W = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   typedef logic [WINDOW_DEPTH-1:0][7:0] window_type;

   typedef struct packed {
      window_type window;
      logic       telemetry_long;
      logic       menu_long;
   } brfc_job_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> design/bus_request_frame_checker.sv
// Bus request frame checker top level: request id registers and front/back wiring.
// Bytes enter on the req_ queue port: a beat moves when req_push is high and req_full
// is low; req_end_of_burst marks the last byte of a burst and starts a frame check.
// Results leave on the rsp_ queue port: the oldest result shows while rsp_empty is
// low and is taken when rsp_pop is high. Only end-of-burst beats produce a result.
// csr_valid/csr_ready write telemetry (index 0) or menu (index 1) request ids;
// csr_ready is always high, and writes belong to quiet periods only.
// The front end takes one byte per cycle, while req_full is low, into a nine-byte
// window and hands each end-of-burst snapshot to a job queue (QUEUE_DEPTH entries).
// The back end walks the crc one byte per cycle, seven steps, and then registers
// the result; a check starts only once the previous result has been popped, so
// the back end does not begin a new burst until its last result has left.
// req_full rises when the job queue is full; a result that is not popped holds
// the back end, which then fills the queue and stalls the byte input.
// Reset clears the burst counter, queue, back-end state and both request ids to
// their defaults; window bytes are only read once rewritten in the same burst.
module bus_request_frame_checker
   import brfc_pkg::*;
#(
   parameter int QUEUE_DEPTH = BRFC_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_end_of_burst,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_packet_id,
   output logic [3:0]             rsp_buttons_pressed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic [7:0]    telemetry_id_ff;
   logic [7:0]    menu_id_ff;
   logic          job_push;
   logic          job_pop;
   logic          queue_full;
   logic          queue_empty;
   brfc_job_type  push_job;
   brfc_job_type  pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         telemetry_id_ff <= TELEMETRY_ID_RESET;
         menu_id_ff <= MENU_ID_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TELEMETRY_ID: telemetry_id_ff <= csr_data;
            CSR_MENU_ID:      menu_id_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   brfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_end_of_burst (req_end_of_burst),
      .queue_full       (queue_full),
      .req_full         (req_full),
      .job_push         (job_push),
      .job              (push_job)
   );

   brfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   brfc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .job_valid            (!queue_empty),
      .job                  (pop_job),
      .job_pop              (job_pop),
      .telemetry_request_id (telemetry_id_ff),
      .menu_request_id      (menu_id_ff),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_status           (rsp_status),
      .rsp_packet_id        (rsp_packet_id),
      .rsp_buttons_pressed  (rsp_buttons_pressed)
   );

endmodule

>>> design/brfc_front.sv
// front end: byte window, burst counter and check job capture
module brfc_front
   import brfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_end_of_burst,
   input  logic         queue_full,
   output logic         req_full,
   output logic         job_push,
   output brfc_job_type job
);

   window_type           window_ff;
   window_type           window_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [COUNT_W-1:0]   count_inc;
   logic                 accept;

   assign req_full = queue_full;
   assign accept = req_push && !queue_full;

   always_comb begin
      window_in = window_ff;
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[WINDOW_DEPTH-1] = req_rx_byte;
      count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      count_in = req_end_of_burst ? '0 : count_inc;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign job_push = accept && req_end_of_burst;
   assign job.window = window_in;
   assign job.telemetry_long = count_inc >= COUNT_W'(TELEMETRY_FRAME_LEN);
   assign job.menu_long = count_inc >= COUNT_W'(MENU_FRAME_LEN);

endmodule

>>> design/brfc_queue.sv
// short job queue between front and back
module brfc_queue
   import brfc_pkg::*;
#(
   parameter int DEPTH = BRFC_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  brfc_job_type push_data,
   input  logic         pop,
   output brfc_job_type pop_data,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   brfc_job_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> design/brfc_back.sv
// back end: byte-serial crc walk, frame decision and result register
module brfc_back
   import brfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  brfc_job_type job,
   output logic         job_pop,
   input  logic [7:0]   telemetry_request_id,
   input  logic [7:0]   menu_request_id,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [1:0]   rsp_status,
   output logic [7:0]   rsp_packet_id,
   output logic [3:0]   rsp_buttons_pressed
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CRC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam int WIN_IDX_W = $clog2(WINDOW_DEPTH);
   localparam logic [2:0] LAST_STEP = 3'(MENU_FRAME_LEN - 3);

   logic [1:0]    state_ff;
   logic [1:0]    state_in;
   logic [2:0]    step_ff;
   logic [2:0]    step_in;
   brfc_job_type  job_ff;
   logic [15:0]   crc_t_ff;
   logic [15:0]   crc_t_in;
   logic [15:0]   crc_m_ff;
   logic [15:0]   crc_m_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [1:0]    status_ff;
   logic [7:0]    packet_id_ff;
   logic [3:0]    buttons_ff;
   logic [1:0]    status_in;
   logic [7:0]    packet_id_in;
   logic [3:0]    buttons_in;
   logic [7:0]    cur_byte;
   logic          t_hdr;
   logic          t_ok;
   logic          m_hdr;
   logic          m_ok;
   window_type    w;

   assign w = job_ff.window;
   assign cur_byte = w[WIN_IDX_W'(step_ff)];
   assign job_pop = (state_ff == ST_IDLE) && job_valid && !rsp_valid_ff;

   always_comb begin
      t_hdr = job_ff.telemetry_long && w[1] == HDR_START && w[2] == HDR_ANSWER
              && w[3] == 8'(TELEMETRY_FRAME_LEN) && w[5] == telemetry_request_id;
      t_ok = t_hdr && w[7] == crc_t_ff[7:0] && w[8] == crc_t_ff[15:8];
      m_hdr = job_ff.menu_long && w[0] == HDR_START && w[1] == HDR_ANSWER
              && w[2] == 8'(MENU_FRAME_LEN) && w[4] == menu_request_id;
      m_ok = m_hdr && w[7] == crc_m_ff[7:0] && w[8] == crc_m_ff[15:8];
      status_in = STATUS_NONE;
      packet_id_in = '0;
      buttons_in = '0;
      if (t_ok) begin
         status_in = STATUS_TELEMETRY;
         packet_id_in = w[4];
      end else if (m_ok) begin
         status_in = STATUS_MENU;
         packet_id_in = w[3];
         buttons_in = ~w[6][7:4];
      end else if (t_hdr || m_hdr) begin
         status_in = STATUS_CRC_ERROR;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      crc_t_in = crc_t_ff;
      crc_m_in = crc_m_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               state_in = ST_CRC;
               step_in = '0;
               crc_t_in = '0;
               crc_m_in = '0;
            end
         end
         ST_CRC: begin
            crc_m_in = crc_step(crc_m_ff, cur_byte);
            if (step_ff != '0) begin
               crc_t_in = crc_step(crc_t_ff, cur_byte);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
      end
      step_ff <= step_in;
      crc_t_ff <= crc_t_in;
      crc_m_ff <= crc_m_in;
      if (state_ff == ST_DONE) begin
         status_ff <= status_in;
         packet_id_ff <= packet_id_in;
         buttons_ff <= buttons_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_packet_id = packet_id_ff;
   assign rsp_buttons_pressed = buttons_ff;

endmodule
